[rtl/dinsu_pkg.sv]
// package: types, constants and helper functions for the danish id number scanner
package dinsu_pkg;

   localparam int OFFSET_BITS = 32;
   localparam int DIGIT_COUNT = 10;
   localparam int SUM_BITS    = 9;

   localparam logic [1:0] CSR_MOD11_ENABLE = 2'd0;
   localparam logic [1:0] CSR_SEPARATOR_A  = 2'd1;
   localparam logic [1:0] CSR_SEPARATOR_B  = 2'd2;

   localparam logic [7:0] RESET_SEPARATOR_A = 8'd45;
   localparam logic [7:0] RESET_SEPARATOR_B = 8'd32;

   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_THREE = 8'h33;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   // modulus 11 by reciprocal: q = (sum * MOD11_RECIP) >> MOD11_SHIFT, exact for sums up to 333
   localparam logic [8:0] MOD11_RECIP = 9'd373;
   localparam int         MOD11_SHIFT = 12;
   localparam logic [3:0] MOD11_BASE  = 4'd11;

   localparam logic [3:0] WEIGHTS [DIGIT_COUNT] = '{
      4'd4, 4'd3, 4'd2, 4'd7, 4'd6, 4'd5, 4'd4, 4'd3, 4'd2, 4'd1
   };

   typedef struct packed {
      logic [7:0] text_char;
      logic       text_end;
   } req_word_type;

   typedef struct packed {
      logic [39:0]            id_digits;
      logic [7:0]             separator_seen;
      logic [OFFSET_BITS-1:0] start_offset;
      logic [OFFSET_BITS-1:0] end_offset;
   } rsp_word_type;

   // boundary character: nul, whitespace or ascii punctuation
   function automatic logic is_boundary(input logic [7:0] c);
      logic ok;
      ok = (c == 8'd0) || (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
      ok = ok || (c >= 8'd33 && c <= 8'd47) || (c >= 8'd58 && c <= 8'd64);
      ok = ok || (c >= 8'd91 && c <= 8'd96) || (c >= 8'd123 && c <= 8'd126);
      return ok;
   endfunction

endpackage

[rtl/danish_id_number_scanner_unit.sv]
// top level: streaming danish personal number scanner with mod 11 check
//
// text enters one byte per word on the req_ channel (text_char, text_end).
// each recognised ten digit number leaves as one word on the rsp_ channel
// carrying its bcd digits, the separator used and its start and end offsets.
// a number is reported when the byte after its tenth digit arrives and is a
// boundary character, or with the tenth digit itself when that byte carries text_end.
// the deciding byte is taken into the input register, then its result into the
// result register, which drives rsp_valid. throughput: one byte per cycle, set
// by the single registered pass that updates the scan state, while no finished
// word is stalled by rsp_ready; the input register lets one more byte be taken
// while a finished word waits. when rsp_ready is low with a word held, the byte
// in the input register waits and req_ready drops once that register is full.
// the csr_ channel writes mod11_enable (0), separator_a (1), separator_b (2)
// and is always ready; write only while the scanner is idle.
// reset clears the scan state and offset counter and loads the register
// defaults (check on, separators '-' and ' '). text_end clears the scan
// state and offset counter after its byte.
module danish_id_number_scanner_unit (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  dinsu_pkg::req_word_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output dinsu_pkg::rsp_word_type rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [1:0]            csr_index,
   input  logic [7:0]            csr_data
);
   import dinsu_pkg::*;

   localparam logic [3:0] PHASE_IDLE     = 4'd0;
   localparam logic [3:0] PHASE_DAY_LO   = 4'd1;
   localparam logic [3:0] PHASE_MONTH_HI = 4'd2;
   localparam logic [3:0] PHASE_MONTH_LO = 4'd3;
   localparam logic [3:0] PHASE_DATE_END = 4'd4;
   localparam logic [3:0] PHASE_YEAR_LO  = 4'd5;
   localparam logic [3:0] PHASE_SEP      = 4'd6;
   localparam logic [3:0] PHASE_SERIAL_2 = 4'd7;
   localparam logic [3:0] PHASE_SERIAL_3 = 4'd8;
   localparam logic [3:0] PHASE_LAST     = 4'd9;

   // configuration
   logic       mod11_enable_ff;
   logic [7:0] separator_a_ff;
   logic [7:0] separator_b_ff;

   // input register
   logic         in_valid_ff;
   req_word_type in_word_ff;

   // scan state
   logic [3:0]             scan_phase_ff, scan_phase_in;
   logic [7:0]             prior_char_ff, prior_char_in;
   logic [3:0]             digit_store_ff [DIGIT_COUNT];
   logic [3:0]             digit_store_in [DIGIT_COUNT];
   logic [7:0]             held_separator_ff, held_separator_in;
   logic                   separator_allowed_ff, separator_allowed_in;
   logic                   leap_required_ff, leap_required_in;
   logic                   match_pending_ff, match_pending_in;
   logic [OFFSET_BITS-1:0] begin_offset_ff, begin_offset_in;
   logic [OFFSET_BITS-1:0] char_position_ff, char_position_in;

   // result register
   logic         rsp_valid_ff;
   rsp_word_type rsp_word_ff, rsp_word_in;
   logic         emit_now;

   logic       advance;
   logic [7:0] c;
   logic       last;
   logic       char_is_num;
   logic [3:0] d;
   logic [3:0] lo;
   logic [3:0] hi;
   logic [4:0] month;
   logic [6:0] year;
   logic [SUM_BITS-1:0] weighted_sum;
   logic [SUM_BITS+8:0] quot_product;
   logic [SUM_BITS-1:0] quot;
   logic [SUM_BITS-1:0] remainder;
   logic [39:0]         bcd_now;
   logic [39:0]         bcd_last;
   logic                tail_nonzero;
   logic                number_ok;
   logic                feb;
   logic                long_month;

   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_word_ff;
   assign csr_ready = 1'b1;

   assign c           = in_word_ff.text_char;
   assign last        = in_word_ff.text_end;
   assign char_is_num = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
   assign d           = char_is_num ? 4'(c - CHAR_ZERO) : 4'd0;

   // candidate number with the tenth digit taken from this byte
   always_comb begin
      weighted_sum = '0;
      bcd_now      = '0;
      bcd_last     = '0;
      for (int i = 0; i < DIGIT_COUNT; i++) begin
         bcd_now  = {bcd_now[35:0], digit_store_ff[i]};
         if (i == DIGIT_COUNT - 1) begin
            bcd_last     = {bcd_last[35:0], d};
            weighted_sum = weighted_sum + SUM_BITS'(d * WEIGHTS[i]);
         end else begin
            bcd_last     = {bcd_last[35:0], digit_store_ff[i]};
            weighted_sum = weighted_sum + SUM_BITS'(digit_store_ff[i] * WEIGHTS[i]);
         end
      end
   end

   assign quot_product = (SUM_BITS+9)'(weighted_sum) * (SUM_BITS+9)'(MOD11_RECIP);
   assign quot         = SUM_BITS'(quot_product >> MOD11_SHIFT);
   assign remainder    = weighted_sum - SUM_BITS'(quot * MOD11_BASE);
   assign tail_nonzero = (digit_store_ff[6] | digit_store_ff[7] | digit_store_ff[8] | d) != 4'd0;
   assign number_ok    = tail_nonzero && (!mod11_enable_ff || remainder == '0);

   // date checks on the fourth digit; the year is taken from the fifth and sixth
   assign month      = 5'(digit_store_ff[2] * 4'd10) + 5'(d);
   assign feb        = (month == 5'd2);
   assign long_month = (month > 5'd7 && !month[0]) || (month < 5'd8 && month[0]);
   assign year       = 7'(digit_store_ff[4] * 4'd10) + 7'(digit_store_ff[5]);

   always_comb begin
      scan_phase_in        = scan_phase_ff;
      prior_char_in        = c;
      digit_store_in       = digit_store_ff;
      held_separator_in    = held_separator_ff;
      separator_allowed_in = separator_allowed_ff;
      leap_required_in     = leap_required_ff;
      match_pending_in     = 1'b0;
      begin_offset_in      = begin_offset_ff;
      char_position_in     = char_position_ff + OFFSET_BITS'(1);
      emit_now             = 1'b0;
      lo                   = 4'd0;
      hi                   = 4'd9;
      rsp_word_in.id_digits      = bcd_now;
      rsp_word_in.separator_seen = held_separator_ff;
      rsp_word_in.start_offset   = begin_offset_ff;
      rsp_word_in.end_offset     = char_position_ff - OFFSET_BITS'(1);

      // number waiting for its trailing byte
      if (match_pending_ff && is_boundary(c)) begin
         emit_now = 1'b1;
      end

      case (scan_phase_ff)
         PHASE_IDLE: begin
            if (is_boundary(prior_char_ff) && c >= CHAR_ZERO && c <= CHAR_THREE) begin
               digit_store_in[0]    = d;
               begin_offset_in      = char_position_ff;
               held_separator_in    = 8'd0;
               separator_allowed_in = 1'b0;
               scan_phase_in        = PHASE_DAY_LO;
            end
         end
         PHASE_SEP: begin
            if (separator_allowed_ff && (c == separator_a_ff || c == separator_b_ff)) begin
               held_separator_in    = c;
               separator_allowed_in = 1'b0;
            end else if (!char_is_num) begin
               scan_phase_in = PHASE_IDLE;
            end else begin
               digit_store_in[6] = d;
               scan_phase_in     = PHASE_SERIAL_2;
               if (leap_required_ff &&
                   ((d < 4'd4 && year == 7'd0) || year[1:0] != 2'd0)) begin
                  scan_phase_in = PHASE_IDLE;
               end
            end
         end
         PHASE_LAST: begin
            scan_phase_in = PHASE_IDLE;
            if (char_is_num) begin
               digit_store_in[9] = d;
               if (number_ok) begin
                  if (last) begin
                     emit_now                   = 1'b1;
                     rsp_word_in.id_digits      = bcd_last;
                     rsp_word_in.end_offset     = char_position_ff;
                  end else begin
                     match_pending_in = 1'b1;
                  end
               end
            end
         end
         PHASE_DAY_LO, PHASE_MONTH_HI, PHASE_MONTH_LO, PHASE_DATE_END, PHASE_YEAR_LO,
         PHASE_SERIAL_2, PHASE_SERIAL_3: begin
            if (scan_phase_ff == PHASE_DAY_LO) begin
               if (digit_store_ff[0] == 4'd0) begin
                  lo = 4'd1;
               end else if (digit_store_ff[0] == 4'd3) begin
                  hi = 4'd1;
               end
            end else if (scan_phase_ff == PHASE_MONTH_HI) begin
               hi = 4'd1;
            end else if (scan_phase_ff == PHASE_MONTH_LO) begin
               if (digit_store_ff[2] == 4'd0) begin
                  lo = 4'd1;
               end else begin
                  hi = 4'd2;
               end
            end else if (scan_phase_ff == PHASE_YEAR_LO) begin
               if (digit_store_ff[4] == 4'd0) begin
                  lo = 4'd1;
               end
            end
            if (!char_is_num || d < lo || d > hi) begin
               scan_phase_in = PHASE_IDLE;
            end else begin
               digit_store_in[scan_phase_ff] = d;
               scan_phase_in                 = scan_phase_ff + 4'd1;
               if (scan_phase_ff == PHASE_MONTH_LO) begin
                  // day is 30 or 31 exactly when the first digit is 3
                  leap_required_in = 1'b0;
                  if (feb) begin
                     leap_required_in = (digit_store_ff[0] == 4'd2) &&
                                        (digit_store_ff[1] == 4'd9);
                     if (digit_store_ff[0] == 4'd3) begin
                        scan_phase_in = PHASE_IDLE;
                     end
                  end else if (digit_store_ff[0] == 4'd3 && digit_store_ff[1] == 4'd1 &&
                               !long_month) begin
                     scan_phase_in = PHASE_IDLE;
                  end
               end
               if (scan_phase_ff == PHASE_YEAR_LO) begin
                  separator_allowed_in = 1'b1;
               end
            end
         end
         default: begin
            scan_phase_in = PHASE_IDLE;
         end
      endcase

      if (last) begin
         scan_phase_in        = PHASE_IDLE;
         prior_char_in        = 8'd0;
         held_separator_in    = 8'd0;
         separator_allowed_in = 1'b0;
         leap_required_in     = 1'b0;
         match_pending_in     = 1'b0;
         begin_offset_in      = '0;
         char_position_in     = '0;
         for (int i = 0; i < DIGIT_COUNT; i++) begin
            digit_store_in[i] = 4'd0;
         end
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mod11_enable_ff <= 1'b1;
         separator_a_ff  <= RESET_SEPARATOR_A;
         separator_b_ff  <= RESET_SEPARATOR_B;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_MOD11_ENABLE: mod11_enable_ff <= csr_data[0];
            CSR_SEPARATOR_A:  separator_a_ff  <= csr_data;
            CSR_SEPARATOR_B:  separator_b_ff  <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
      if (req_ready && req_valid) begin
         in_word_ff <= req_data;
      end
   end

   // scan state
   always_ff @(posedge clock) begin
      if (reset) begin
         scan_phase_ff        <= PHASE_IDLE;
         prior_char_ff        <= 8'd0;
         held_separator_ff    <= 8'd0;
         separator_allowed_ff <= 1'b0;
         leap_required_ff     <= 1'b0;
         match_pending_ff     <= 1'b0;
         begin_offset_ff      <= '0;
         char_position_ff     <= '0;
         for (int i = 0; i < DIGIT_COUNT; i++) begin
            digit_store_ff[i] <= 4'd0;
         end
      end else if (advance) begin
         scan_phase_ff        <= scan_phase_in;
         prior_char_ff        <= prior_char_in;
         held_separator_ff    <= held_separator_in;
         separator_allowed_ff <= separator_allowed_in;
         leap_required_ff     <= leap_required_in;
         match_pending_ff     <= match_pending_in;
         begin_offset_ff      <= begin_offset_in;
         char_position_ff     <= char_position_in;
         digit_store_ff       <= digit_store_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= emit_now;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (advance && emit_now) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

endmodule
